FILE: rtl/bounded_deque_engine_defines.svh
// assertion macros shared by the deque engine rtl
// no dependencies; included by files that carry assertions
`ifndef BOUNDED_DEQUE_ENGINE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define BDE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bde check failed");
// next-cycle implication, disabled during reset
`define BDE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bde check failed");
`else
`define BDE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BDE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/bde_pkg.sv
// shared types and codes for the deque engine
// no dependencies
`default_nettype none

package bde_pkg;

  // request kinds
  localparam logic [1:0] REQ_PUSH_BACK = 2'd0;
  localparam logic [1:0] REQ_POP_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_BACK  = 2'd2;
  localparam logic [1:0] REQ_PEEK_BACK = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // what one cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  // what a whole row of cells does in a cycle
  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_PUT_AT_COUNT,
    CHAIN_PUSH_HEAD,
    CHAIN_POP_HEAD
  } chain_mode_t;

endpackage

`default_nettype wire

FILE: rtl/bounded_deque_engine.sv
// bounded deque engine: the result strobes on done in the cycle after start is
// taken; one request per cycle while busy is low, set by the cell update
// of both cell rows and the count register; the receiver cannot stall results
// reset (rst, synchronous) empties the store and holds busy high until the clock edge
// that samples rst low; stored words are not cleared and are never read before written
// depends on bde_pkg, bde_chain, bde_cell and bounded_deque_engine_defines.svh
`default_nettype none
`include "bounded_deque_engine_defines.svh"

module bounded_deque_engine
  import bde_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [DATA_WIDTH-1:0]         data_in,
  output logic                          done,
  output logic [DATA_WIDTH-1:0]         data_out,
  output logic [1:0]                    status,
  output logic [$clog2(DEPTH+1)-1:0]    count,
  output logic                          is_empty,
  output logic                          is_full
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  // two rows hold the same words: the front row keeps the front word in cell 0
  // and words in front-to-back order; the back row keeps the back word in cell 0
  // and words in back-to-front order, so both ends are read at a fixed cell
  logic                  accept;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  chain_mode_t           front_mode;
  chain_mode_t           back_mode;
  logic [DATA_WIDTH-1:0] front_head;
  logic [DATA_WIDTH-1:0] back_head;
  logic [DATA_WIDTH-1:0] data_next;
  logic [1:0]            status_next;
  logic                  cnt_is_zero;
  logic                  cnt_is_max;

  assign accept      = start && !busy;
  assign cnt_is_zero = (cnt == '0);
  assign cnt_is_max  = (cnt == CNT_MAX);

  // request decode: pick what each row does and the result to report
  always_comb begin
    front_mode  = CHAIN_HOLD;
    back_mode   = CHAIN_HOLD;
    cnt_next    = cnt;
    data_next   = '0;
    status_next = ST_OK;
    if (accept) begin
      if (req_type == REQ_PUSH_BACK) begin
        if (cnt_is_max) begin
          // full: word dropped, nothing moves
          status_next = ST_FULL;
        end else begin
          // front row writes just past its last word, back row shifts in at its head
          front_mode = CHAIN_PUT_AT_COUNT;
          back_mode  = CHAIN_PUSH_HEAD;
          cnt_next   = cnt + CNT_W'(1);
        end
      end else if (cnt_is_zero) begin
        status_next = ST_EMPTY;
      end else begin
        case (req_type)
          REQ_POP_FRONT: begin
            // back row loses its far end simply by the count going down
            data_next  = front_head;
            front_mode = CHAIN_POP_HEAD;
            cnt_next   = cnt - CNT_W'(1);
          end
          REQ_POP_BACK: begin
            data_next = back_head;
            back_mode = CHAIN_POP_HEAD;
            cnt_next  = cnt - CNT_W'(1);
          end
          default: begin
            // peek back reads without any move
            data_next = back_head;
          end
        endcase
      end
    end
  end

  bde_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_front_row (
    .clk       (clk),
    .mode      (front_mode),
    .count     (cnt),
    .load_data (data_in),
    .head      (front_head)
  );

  bde_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_back_row (
    .clk       (clk),
    .mode      (back_mode),
    .count     (cnt),
    .load_data (data_in),
    .head      (back_head)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      busy <= 1'b0;
      done <= accept;
    end
  end

  // result registers, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out <= data_next;
      status   <= status_next;
      count    <= cnt_next;
      is_empty <= (cnt_next == '0);
      is_full  <= (cnt_next == CNT_MAX);
    end
  end

  // strobe comes in the cycle after each taken request
  `BDE_ASSERT_NXT(a_done_after_accept, clk, rst, accept, done)
  `BDE_ASSERT_NXT(a_no_stray_done, clk, rst, !accept, !done)
  // reported count tracks the stored count
  `BDE_ASSERT_IMP(a_count_tracks, clk, rst, done, count == cnt)
  // a dropped push only happens at full, an empty report returns no word
  `BDE_ASSERT_IMP(a_full_drop, clk, rst, done && status == ST_FULL, is_full)
  `BDE_ASSERT_IMP(a_empty_report, clk, rst, done && status == ST_EMPTY,
                  is_empty && data_out == '0)
  // taken push with room grows the store by one
  `BDE_ASSERT_NXT(a_push_grows, clk, rst,
                  accept && req_type == REQ_PUSH_BACK && !cnt_is_max,
                  cnt == $past(cnt) + CNT_W'(1))

endmodule

`default_nettype wire

FILE: rtl/bde_cell.sv
// one storage cell of the deque row: holds a word, loads or takes a neighbor
// depends on bde_pkg
`default_nettype none

module bde_cell
  import bde_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] load_data,
  output logic [DATA_WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:       data <= data;
      CELL_LOAD:       data <= load_data;
      CELL_FROM_LEFT:  data <= left_data;
      CELL_FROM_RIGHT: data <= right_data;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bde_chain.sv
// row of deque cells with cell 0 as the head; per-cell op decode
// depends on bde_pkg and bde_cell
`default_nettype none

module bde_chain
  import bde_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  chain_mode_t           mode,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] load_data,
  output logic [DATA_WIDTH-1:0] head
);

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_op_t              op;
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_left
      assign left_data = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_right
      assign right_data = cell_q[i+1];
    end

    always_comb begin
      unique case (mode)
        CHAIN_HOLD:         op = CELL_HOLD;
        CHAIN_PUT_AT_COUNT: op = (count == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
        CHAIN_PUSH_HEAD:    op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
        CHAIN_POP_HEAD:     op = CELL_FROM_RIGHT;
      endcase
    end

    bde_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .left_data  (left_data),
      .right_data (right_data),
      .load_data  (load_data),
      .data       (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

`default_nettype wire
